### rtl/throb_pkg.sv
// throb_pkg: shared types, character codes, symbol tables and lookup functions
// for the throb tone-pair encoder
// no dependencies

package throb_pkg;

    // symbol indexes are six bits wide (up to 55 symbols)
    typedef logic [5:0] sym_t;

    // one tone pair, first tone in the high nibble
    typedef struct packed {
        logic [3:0] first;
        logic [3:0] second;
    } tone_pair_t;

    // result of an x-family character lookup
    typedef struct packed {
        logic hit;
        sym_t sym;
    } x_lookup_t;

    localparam int BaseSyms = 45;
    localparam int XSyms    = 55;

    // special symbols of the base family
    localparam sym_t BaseIdleSym   = 6'd0;
    localparam sym_t BaseSpaceSym  = 6'd44;
    localparam sym_t ShiftSym      = 6'd5;
    localparam sym_t ShiftQuestion = 6'd20;
    localparam sym_t ShiftAt       = 6'd13;
    localparam sym_t ShiftDash     = 6'd9;
    localparam sym_t ShiftNewline  = 6'd0;

    // character codes with special handling
    localparam logic [7:0] CharQuestion = 8'h3F;
    localparam logic [7:0] CharAt       = 8'h40;
    localparam logic [7:0] CharDash     = 8'h2D;
    localparam logic [7:0] CharNewline  = 8'h0A;
    localparam logic [7:0] CharCr       = 8'h0D;

    localparam tone_pair_t BASE_PAIRS [BaseSyms] = '{
        8'h44, 8'h34, 8'h01, 8'h02, 8'h03, 8'h35, 8'h04, 8'h05, 8'h06, 8'h26,
        8'h07, 8'h12, 8'h13, 8'h17, 8'h14, 8'h45, 8'h15, 8'h18, 8'h23, 8'h24,
        8'h08, 8'h25, 8'h78, 8'h27, 8'h22, 8'h11, 8'h00, 8'h28, 8'h36, 8'h37,
        8'h38, 8'h46, 8'h47, 8'h48, 8'h56, 8'h57, 8'h58, 8'h67, 8'h68, 8'h77,
        8'h66, 8'h55, 8'h33, 8'h88, 8'h16
    };

    localparam tone_pair_t X_PAIRS [XSyms] = '{
        8'h5a, 8'h05, 8'h15, 8'h14, 8'h16, 8'h17, 8'h45, 8'h18, 8'h19, 8'h37,
        8'h35, 8'h1a, 8'h23, 8'h24, 8'h25, 8'h58, 8'h59, 8'h26, 8'h27, 8'h28,
        8'h57, 8'h56, 8'h29, 8'h2a, 8'h34, 8'h36, 8'h38, 8'h39, 8'h01, 8'h02,
        8'h03, 8'h04, 8'h06, 8'h07, 8'h08, 8'h09, 8'h12, 8'h13, 8'h3a, 8'h46,
        8'h47, 8'h48, 8'h49, 8'h4a, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h78, 8'h79,
        8'h7a, 8'h89, 8'h8a, 8'h9a, 8'h0a
    };

    // lowercase letters to upper case, everything else unchanged
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // base family: folded character to symbol, unknown maps to space
    function automatic sym_t base_symbol(input logic [7:0] c);
        sym_t s;
        case (c) inside
            8'h45:          s = 6'd43;            // 'E' sits near the end
            [8'h41:8'h5A]:  s = 6'(c - 8'd64);    // other letters
            8'h30:          s = 6'd36;            // '0'
            [8'h31:8'h39]:  s = 6'(c - 8'd22);    // '1'..'9'
            8'h2C:          s = 6'd37;            // ','
            8'h2E:          s = 6'd38;            // '.'
            8'h27:          s = 6'd39;            // apostrophe
            8'h2F:          s = 6'd40;            // '/'
            8'h29:          s = 6'd41;            // ')'
            8'h28:          s = 6'd42;            // '('
            default:        s = BaseSpaceSym;
        endcase
        return s;
    endfunction

    // x family: folded character to symbol; space and unknown give no hit
    function automatic x_lookup_t x_symbol(input logic [7:0] c);
        x_lookup_t r;
        r.hit = 1'b1;
        case (c) inside
            [8'h41:8'h5A]:  r.sym = 6'(c - 8'd63);  // letters
            8'h30:          r.sym = 6'd37;          // '0'
            [8'h31:8'h39]:  r.sym = 6'(c - 8'd21);  // '1'..'9'
            8'h2C:          r.sym = 6'd38;          // ','
            8'h2E:          r.sym = 6'd39;          // '.'
            8'h27:          r.sym = 6'd40;          // apostrophe
            8'h2F:          r.sym = 6'd41;          // '/'
            8'h29:          r.sym = 6'd42;          // ')'
            8'h28:          r.sym = 6'd43;          // '('
            8'h23:          r.sym = 6'd44;          // '#'
            8'h22:          r.sym = 6'd45;          // double quote
            8'h2B:          r.sym = 6'd46;          // '+'
            8'h2D:          r.sym = 6'd47;          // '-'
            8'h3B:          r.sym = 6'd48;          // ';'
            8'h3A:          r.sym = 6'd49;          // ':'
            8'h3F:          r.sym = 6'd50;          // '?'
            8'h21:          r.sym = 6'd51;          // '!'
            8'h40:          r.sym = 6'd52;          // '@'
            8'h3D:          r.sym = 6'd53;          // '='
            8'h0A:          r.sym = 6'd54;          // newline
            default: begin
                r.hit = 1'b0;
                r.sym = 6'd0;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/throb_char_to_tone_pair_encoder.sv
// throb_char_to_tone_pair_encoder: text byte to tone-pair symbol encoder
// depends on throb_pkg (tables, character codes, lookup functions)
//
// channel  direction  handshake              payload
// -------  ---------  ---------------------  ---------------------------------
// s_       in         s_valid / s_ready      s_command, s_char_code
// m_       out        m_valid / m_ready      m_tone_first, m_tone_second, m_last
// cfg_     in         cfg_valid / cfg_ready  cfg_family_mode
//
// an input beat lands in the item register; its result beats then move into the
// output register one per cycle while the output is not stalled, as many as the
// item has results (1, 2 or 4), and a carriage return in the base family retires
// with no result; back-to-back items stream without gaps
// reset (aresetn low, synchronous) empties both registers, selects the base
// family and clears the idle/space flip
// a stalled output holds the item register, and s_ready drops until the
// item's last beat can move on

module throb_char_to_tone_pair_encoder
    import throb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_char_code,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_tone_first,
    output logic [3:0] m_tone_second,
    output logic       m_last,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_family_mode
);

    // config register
    logic family_mode_reg;

    // item register
    logic       in_valid_reg;
    logic       command_reg;
    logic [7:0] char_code_reg;
    logic [1:0] idx_reg;           // which result of the item is next
    logic [1:0] idx_next;

    // flip between symbols 0 and 1 for idle/space in the x family
    logic idle_is_one_reg;
    logic idle_is_one_next;

    // output register
    logic       m_valid_reg;
    logic [3:0] m_tone_first_reg;
    logic [3:0] m_tone_second_reg;
    logic       m_last_reg;

    // per-item decode
    logic [7:0] folded;
    x_lookup_t  xl;
    logic       has_out;           // item produces at least one result
    logic [1:0] last_idx;          // index of its final result
    sym_t       sym;
    tone_pair_t pair;

    logic out_free;                // output register can take a beat
    logic emit;                    // a result beat moves into the output register
    logic item_done;               // the held item retires this cycle
    logic s_accept;

    assign cfg_ready = 1'b1;

    // decode the held item at the current result index
    always_comb begin
        folded           = fold_case(char_code_reg);
        xl               = x_symbol(folded);
        has_out          = 1'b1;
        last_idx         = 2'd0;
        sym              = BaseIdleSym;
        idle_is_one_next = idle_is_one_reg;
        if (command_reg) begin
            // preamble: four idle symbols, alternating 0/1 in the x family
            last_idx         = 2'd3;
            sym              = family_mode_reg ? {5'd0, idx_reg[0]} : BaseIdleSym;
            idle_is_one_next = 1'b0;
        end else if (!family_mode_reg) begin
            case (char_code_reg)
                CharQuestion: begin
                    last_idx = 2'd1;
                    sym      = (idx_reg == 2'd0) ? ShiftSym : ShiftQuestion;
                end
                CharAt: begin
                    last_idx = 2'd1;
                    sym      = (idx_reg == 2'd0) ? ShiftSym : ShiftAt;
                end
                CharDash: begin
                    last_idx = 2'd1;
                    sym      = (idx_reg == 2'd0) ? ShiftSym : ShiftDash;
                end
                CharNewline: begin
                    last_idx = 2'd1;
                    sym      = (idx_reg == 2'd0) ? ShiftSym : ShiftNewline;
                end
                CharCr: begin
                    has_out = 1'b0;
                end
                default: begin
                    sym = base_symbol(folded);
                end
            endcase
        end else begin
            if (xl.hit) begin
                sym = xl.sym;
            end else begin
                // space or unknown: current space symbol, then flip
                sym              = idle_is_one_reg ? 6'd0 : 6'd1;
                idle_is_one_next = ~idle_is_one_reg;
            end
        end
        pair = family_mode_reg ? X_PAIRS[sym] : BASE_PAIRS[sym];
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = in_valid_reg && has_out && out_free;
    assign item_done = in_valid_reg && (!has_out || (out_free && idx_reg == last_idx));
    assign s_ready   = !in_valid_reg || item_done;
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        idx_next = idx_reg;
        if (item_done) begin
            idx_next = 2'd0;
        end else if (emit) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            family_mode_reg <= 1'b0;
            in_valid_reg    <= 1'b0;
            idx_reg         <= 2'd0;
            idle_is_one_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                family_mode_reg <= cfg_family_mode;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            idx_reg <= idx_next;
            if (item_done) begin
                idle_is_one_reg <= idle_is_one_next;
            end
            if (out_free) begin
                m_valid_reg <= emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            command_reg   <= s_command;
            char_code_reg <= s_char_code;
        end
        if (emit) begin
            m_tone_first_reg  <= pair.first;
            m_tone_second_reg <= pair.second;
            m_last_reg        <= (idx_reg == last_idx);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tone_first  = m_tone_first_reg;
    assign m_tone_second = m_tone_second_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTHESIS
    // result index never runs past the item's final result
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && has_out |-> idx_reg <= last_idx)
        else $error("result index beyond last result");

    // a nonzero result index only exists while an item is held
    a_idx_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd0 |-> in_valid_reg)
        else $error("result index set with no item held");

    // a newly taken item starts at its first result
    a_new_item_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg && idx_reg == 2'd0)
        else $error("new item does not start at first result");

    // a start command always leaves the flip cleared
    a_start_clears_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        item_done && command_reg |=> !idle_is_one_reg)
        else $error("start command left idle flip set");
`endif

endmodule

### sim/throb_tone_checker.sv
// throb_tone_checker: testbench command and family codes, plus the result checker
// of the throb tone-pair encoder; it predicts every tone beat and compares it
// depends on throb_pkg for symbol indexes and special character codes

package throb_tb_pkg;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_START  = 1'b1
    } command_t;

    typedef enum logic {
        FAM_BASE = 1'b0,
        FAM_X    = 1'b1
    } family_t;

    localparam logic [7:0] CharSpace = 8'h20;

endpackage

module throb_tone_checker
    import throb_pkg::*;
    import throb_tb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_char_code,

    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [3:0] m_tone_first,
    input  logic [3:0] m_tone_second,
    input  logic       m_last,

    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_family_mode,

    output int         pending,
    output int         fail_count
);

    typedef struct packed {
        logic [3:0] first;
        logic [3:0] second;
        logic       last;
    } tone_beat_t;

    // tone pairs, first tone in the high nibble
    localparam logic [7:0] BASE_TONES [BaseSyms] = '{
        8'h44, 8'h34, 8'h01, 8'h02, 8'h03, 8'h35, 8'h04, 8'h05, 8'h06, 8'h26,
        8'h07, 8'h12, 8'h13, 8'h17, 8'h14, 8'h45, 8'h15, 8'h18, 8'h23, 8'h24,
        8'h08, 8'h25, 8'h78, 8'h27, 8'h22, 8'h11, 8'h00, 8'h28, 8'h36, 8'h37,
        8'h38, 8'h46, 8'h47, 8'h48, 8'h56, 8'h57, 8'h58, 8'h67, 8'h68, 8'h77,
        8'h66, 8'h55, 8'h33, 8'h88, 8'h16
    };

    localparam logic [7:0] X_TONES [XSyms] = '{
        8'h5A, 8'h05, 8'h15, 8'h14, 8'h16, 8'h17, 8'h45, 8'h18, 8'h19, 8'h37,
        8'h35, 8'h1A, 8'h23, 8'h24, 8'h25, 8'h58, 8'h59, 8'h26, 8'h27, 8'h28,
        8'h57, 8'h56, 8'h29, 8'h2A, 8'h34, 8'h36, 8'h38, 8'h39, 8'h01, 8'h02,
        8'h03, 8'h04, 8'h06, 8'h07, 8'h08, 8'h09, 8'h12, 8'h13, 8'h3A, 8'h46,
        8'h47, 8'h48, 8'h49, 8'h4A, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h78, 8'h79,
        8'h7A, 8'h89, 8'h8A, 8'h9A, 8'h0A
    };

    // character carried by each symbol, zero where the slot has none
    localparam logic [7:0] BASE_CHARS [BaseSyms] = '{
        8'h00, "A", "B", "C", "D", 8'h00, "F", "G", "H", "I",
        "J", "K", "L", "M", "N", "O", "P", "Q", "R", "S",
        "T", "U", "V", "W", "X", "Y", "Z", "1", "2", "3",
        "4", "5", "6", "7", "8", "9", "0", ",", ".", "'",
        "/", ")", "(", "E", " "
    };

    localparam logic [7:0] X_CHARS [XSyms] = '{
        8'h00, " ", "A", "B", "C", "D", "E", "F", "G", "H",
        "I", "J", "K", "L", "M", "N", "O", "P", "Q", "R",
        "S", "T", "U", "V", "W", "X", "Y", "Z", "1", "2",
        "3", "4", "5", "6", "7", "8", "9", "0", ",", ".",
        "'", "/", ")", "(", "#", "\"", "+", "-", ";", ":",
        "?", "!", "@", "=", CharNewline
    };

    family_t    family;
    logic       idle_on_one;
    tone_beat_t expected_tones [$];
    tone_beat_t want;

    // symbol of a folded character, -1 when the set does not hold it
    function automatic int char_symbol(input family_t fam, input logic [7:0] c);
        int found;
        found = -1;
        if (c != 8'h00) begin
            if (fam == FAM_X) begin
                for (int i = 0; i < XSyms; i++)
                    if (found < 0 && X_CHARS[i] == c) found = i;
            end else begin
                for (int i = 0; i < BaseSyms; i++)
                    if (found < 0 && BASE_CHARS[i] == c) found = i;
            end
        end
        return found;
    endfunction

    // queues the tone beats that one input beat should cause
    function automatic void predict_tones(input command_t cmd, input logic [7:0] code);
        sym_t       syms [4];
        int         n;
        int         hit;
        logic [7:0] c;
        logic [7:0] pair;
        n = 0;
        c = (code >= "a" && code <= "z") ? code - 8'h20 : code;
        if (cmd == CMD_START) begin
            idle_on_one = 1'b0;
            for (int i = 0; i < 4; i++) begin
                if (family == FAM_X) begin
                    syms[n] = sym_t'(idle_on_one);
                    idle_on_one = ~idle_on_one;
                end else begin
                    syms[n] = BaseIdleSym;
                end
                n++;
            end
        end else if (family == FAM_BASE) begin
            case (code)
                CharQuestion: begin
                    syms[0] = ShiftSym;
                    syms[1] = ShiftQuestion;
                    n = 2;
                end
                CharAt: begin
                    syms[0] = ShiftSym;
                    syms[1] = ShiftAt;
                    n = 2;
                end
                CharDash: begin
                    syms[0] = ShiftSym;
                    syms[1] = ShiftDash;
                    n = 2;
                end
                CharNewline: begin
                    syms[0] = ShiftSym;
                    syms[1] = ShiftNewline;
                    n = 2;
                end
                CharCr: n = 0;
                default: begin
                    hit = char_symbol(FAM_BASE, c);
                    syms[0] = (hit < 0) ? BaseSpaceSym : sym_t'(hit);
                    n = 1;
                end
            endcase
        end else begin
            hit = char_symbol(FAM_X, c);
            if (hit < 0 || c == CharSpace) begin
                // space or an unknown character swaps the idle and space symbols
                syms[0] = idle_on_one ? 6'd0 : 6'd1;
                idle_on_one = ~idle_on_one;
            end else begin
                syms[0] = sym_t'(hit);
            end
            n = 1;
        end
        for (int i = 0; i < n; i++) begin
            pair = (family == FAM_X) ? X_TONES[syms[i]] : BASE_TONES[syms[i]];
            expected_tones.insert(expected_tones.size(),
                                  tone_beat_t'({pair[7:4], pair[3:0], i == n - 1}));
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            family      = FAM_BASE;
            idle_on_one = 1'b0;
            expected_tones.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tones.size() == 0) begin
                    $display("%0t unexpected tone beat: expected none, got %0d/%0d last %0d",
                             $time, m_tone_first, m_tone_second, m_last);
                    fail_count++;
                end else begin
                    want = expected_tones.pop_front();
                    if (m_tone_first !== want.first) begin
                        $display("%0t tone_first: expected %0d, got %0d",
                                 $time, want.first, m_tone_first);
                        fail_count++;
                    end
                    if (m_tone_second !== want.second) begin
                        $display("%0t tone_second: expected %0d, got %0d",
                                 $time, want.second, m_tone_second);
                        fail_count++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t last: expected %0d, got %0d",
                                 $time, want.last, m_last);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) family = family_t'(cfg_family_mode);
            if (s_valid && s_ready) predict_tones(command_t'(s_command), s_char_code);
        end
        pending = expected_tones.size();
    end

endmodule

### sim/tb_throb_char_to_tone_pair_encoder.sv
// tb_throb_char_to_tone_pair_encoder: stimulus and verdict for the tone-pair encoder
// directed characters per family, then random text in several family settings
// depends on throb_pkg, and on throb_tb_pkg and throb_tone_checker from throb_tone_checker.sv

module tb_throb_char_to_tone_pair_encoder;
    import throb_pkg::*;
    import throb_tb_pkg::*;

    // cycles to let a beat with no result retire before a register write
    localparam int DRAIN_CYCLES = 8;
    // cycles with no beat on any channel before the run is called hung
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 60;

    // base family: shift characters, carriage return, case folding, unknown bytes
    localparam logic [7:0] BASE_TEXT [13] = '{
        CharQuestion, CharAt, CharDash, CharNewline, CharCr, "a", "z", "E",
        8'h00, 8'hFF, CharSpace, "0", "9"
    };

    // x family: spaces flip idle and space, a start in the middle clears the flip
    localparam logic [7:0] X_TEXT [11] = '{
        CharSpace, CharCr, "z", 8'h00, CharSpace, CharQuestion, CharAt,
        CharNewline, "=", 8'h80, CharSpace
    };

    // family per random phase, both extremes and repeated writes
    localparam family_t PHASE_FAMILY [6] = '{
        FAM_X, FAM_BASE, FAM_BASE, FAM_X, FAM_X, FAM_BASE
    };

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic       s_command       = 1'b0;
    logic [7:0] s_char_code     = 8'h00;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [3:0] m_tone_first;
    logic [3:0] m_tone_second;
    logic       m_last;
    logic       cfg_valid       = 1'b0;
    logic       cfg_ready;
    logic       cfg_family_mode = 1'b0;

    int    pending;
    int    fail_count;
    int    quiet_cycles = 0;
    int    stall_left   = 0;
    int    hold;
    bit    steady       = 1'b0;
    string char_pool    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789,.'/()#\"+-;:?!@=";

    always #5 aclk = ~aclk;

    throb_char_to_tone_pair_encoder u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_char_code     (s_char_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tone_first    (m_tone_first),
        .m_tone_second   (m_tone_second),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_family_mode (cfg_family_mode)
    );

    throb_tone_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_char_code     (s_char_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tone_first    (m_tone_first),
        .m_tone_second   (m_tone_second),
        .m_last          (m_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_family_mode (cfg_family_mode),
        .pending         (pending),
        .fail_count      (fail_count)
    );

    // result side: after every accepted beat, hold ready low for a random stall, or not at all in a steady phase
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (m_valid && m_ready) begin
            hold = steady ? 0 : $urandom_range(0, 5);
            m_ready    <= (hold == 0);
            stall_left <= hold;
        end else if (!m_ready) begin
            // stall ran out, take the next beat
            if (stall_left <= 1) m_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // hang detection: any beat on any channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT - 1) begin
            $display("tb_throb_char_to_tone_pair_encoder: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input beat, preceded by a random gap unless the phase is steady;
    // valid stays high across back-to-back beats
    task automatic send_item(input command_t cmd, input logic [7:0] code);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_char_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // register write, only called once the encoder is idle
    task automatic write_family(input family_t fam);
        cfg_valid       <= 1'b1;
        cfg_family_mode <= fam;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for every predicted beat, then let a silent beat retire
    task automatic drain;
        s_valid <= 1'b0;
        // let the checker see the last accepted beat before polling pending
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int         pick;
        command_t   cmd;
        logic [7:0] code;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed base family
        write_family(FAM_BASE);
        send_item(CMD_START, 8'hFF);
        for (int i = 0; i < $size(BASE_TEXT); i++) send_item(CMD_ENCODE, BASE_TEXT[i]);
        drain();

        // directed x family, with a second start after a few flips
        write_family(FAM_X);
        send_item(CMD_START, 8'h00);
        for (int i = 0; i < $size(X_TEXT); i++) begin
            if (i == 5) send_item(CMD_START, 8'hA5);
            send_item(CMD_ENCODE, X_TEXT[i]);
        end

        // random text, every third phase with no idling on either side
        for (int p = 0; p < $size(PHASE_FAMILY); p++) begin
            drain();
            write_family(PHASE_FAMILY[p]);
            steady = (p % 3 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                cmd  = CMD_ENCODE;
                code = 8'($urandom);
                if (pick < 8) begin
                    // start with a random byte that should be ignored
                    cmd = CMD_START;
                end else if (pick < 50) begin
                    code = char_pool[$urandom_range(0, char_pool.len() - 1)];
                end else if (pick < 62) begin
                    code = CharSpace;
                end else if (pick < 74) begin
                    case ($urandom_range(0, 4))
                        0:       code = CharQuestion;
                        1:       code = CharAt;
                        2:       code = CharDash;
                        3:       code = CharNewline;
                        default: code = CharCr;
                    endcase
                end
                // otherwise any byte, unknown ones encode as space
                send_item(cmd, code);
            end
            steady = 1'b0;
        end
        drain();

        if (fail_count == 0) begin
            $display("tb_throb_char_to_tone_pair_encoder: clean");
        end else begin
            $display("tb_throb_char_to_tone_pair_encoder: errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/throb_pkg.sv
rtl/throb_char_to_tone_pair_encoder.sv
sim/throb_tone_checker.sv
sim/tb_throb_char_to_tone_pair_encoder.sv
